@@ hw/rtl/trdt_pkg.sv @@
// Shared types and constants for the trace replay delay timer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package trdt_pkg;

  // Time base and limits, in tenths of a millisecond
  localparam logic [13:0] TENTHS_PER_SEC = 14'd10000;
  localparam logic [13:0] BORROW_BASE    = 14'd9999;
  localparam logic [13:0] MAX_STEP       = 14'd9999;
  localparam logic [15:0] MAX16          = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_DELAY_STEP    = 2'd0;
  localparam logic [1:0] CFG_OVERFLOW_MARK = 2'd1;
  localparam logic [1:0] CFG_AUTO_FLOOR    = 2'd2;
  localparam logic [1:0] CFG_START_FLOOR   = 2'd3;

  // Request codes
  localparam logic REQ_INIT  = 1'b0;
  localparam logic REQ_STAMP = 1'b1;

  // One input item as held in the input register
  typedef struct packed {
    logic        req_type;
    logic [15:0] stamp_seconds;
    logic [13:0] stamp_tenth_ms;
    logic [15:0] read_level;
    logic [15:0] write_fill;
    logic        buffer_stopped;
  } item_t;

  // Adaptive extra delay and reload floor
  typedef struct packed {
    logic [13:0] tenth_ms;
    logic [15:0] seconds;
    logic [15:0] floor_value;
  } delay_t;

endpackage

@@ hw/rtl/trace_replay_delay_timer.sv @@
// Top level of the trace replay delay timer: ports, configuration registers,
// input and result registers. Depends on trdt_pkg, trdt_delay, trdt_reload.
//
//   Channel | Ports                                         | Direction
//   --------+-----------------------------------------------+----------
//   input   | in_valid/in_ready, in_req_type .. in_buffer_* | in
//   result  | out_valid/out_ready, out_reload_value, ...    | out
//   config  | cfg_wr_en, cfg_index, cfg_data                | in
//
// One item per cycle while the result side does not stall: a transfer lands in
// the input register, the delay and reload logic works on it combinationally
// and writes the result register, whose valid rises as the item leaves.
// An initialise request gives no result and never waits on the result side.
// A stalled result holds; a timestamped item then waits in the input register
// and in_ready stays low until the result transfers. Synchronous active-low
// reset clears the valid flags and delay and reference state and loads the
// configuration defaults; item and result data registers are not reset.
`timescale 1ns / 1ps

module trace_replay_delay_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_stamp_seconds,
  input  logic [13:0] in_stamp_tenth_ms,
  input  logic [15:0] in_read_level,
  input  logic [15:0] in_write_fill,
  input  logic        in_buffer_stopped,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_reload_value,
  output logic        out_floor_applied,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import trdt_pkg::*;

  logic [13:0] delay_step_r;
  logic [15:0] overflow_mark_r;
  logic        auto_floor_r;
  logic [15:0] start_floor_r;

  item_t       s1_item_r;
  logic        s1_valid_r;
  logic        s1_adv;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] out_reload_r;
  logic        out_floor_r;

  delay_t      delay_new;
  logic [15:0] reload_value;
  logic        floor_applied;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_step_r    <= 14'd100;
      overflow_mark_r <= 16'd32768;
      auto_floor_r    <= 1'b0;
      start_floor_r   <= 16'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DELAY_STEP:    delay_step_r    <= cfg_data[13:0];
        CFG_OVERFLOW_MARK: overflow_mark_r <= cfg_data;
        CFG_AUTO_FLOOR:    auto_floor_r    <= cfg_data[0];
        CFG_START_FLOOR:   start_floor_r   <= cfg_data;
        default:           delay_step_r    <= delay_step_r;
      endcase
    end
  end

  // Advance the input register when its item needs no result slot or one is free
  assign s1_adv   = s1_valid_r &&
                    ((s1_item_r.req_type == REQ_INIT) || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.req_type       <= in_req_type;
      s1_item_r.stamp_seconds  <= in_stamp_seconds;
      s1_item_r.stamp_tenth_ms <= in_stamp_tenth_ms;
      s1_item_r.read_level     <= in_read_level;
      s1_item_r.write_fill     <= in_write_fill;
      s1_item_r.buffer_stopped <= in_buffer_stopped;
    end
  end

  trdt_delay u_delay (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (s1_adv),
    .item          (s1_item_r),
    .delay_step    (delay_step_r),
    .overflow_mark (overflow_mark_r),
    .auto_floor    (auto_floor_r),
    .start_floor   (start_floor_r),
    .delay_new     (delay_new)
  );

  trdt_reload u_reload (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (s1_adv),
    .item          (s1_item_r),
    .delay_new     (delay_new),
    .reload_value  (reload_value),
    .floor_applied (floor_applied)
  );

  // Result register: load on a timestamped item, drop on a transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && (s1_item_r.req_type == REQ_STAMP)) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_item_r.req_type == REQ_STAMP)) begin
      out_reload_r <= reload_value;
      out_floor_r  <= floor_applied;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reload_value  = out_reload_r;
  assign out_floor_applied = out_floor_r;

endmodule

@@ hw/rtl/trdt_delay.sv @@
// Adaptive extra delay and reload floor: state registers and update logic.
// Depends on trdt_pkg.
`timescale 1ns / 1ps

module trdt_delay (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  trdt_pkg::item_t     item,
  input  logic [13:0]         delay_step,
  input  logic [15:0]         overflow_mark,
  input  logic                auto_floor,
  input  logic [15:0]         start_floor,
  output trdt_pkg::delay_t    delay_new
);
  import trdt_pkg::*;

  delay_t      dly_r;
  delay_t      dly_nxt;
  logic [13:0] step;
  logic        grow;
  delay_t      base;
  logic [14:0] grow_sum;

  // Clamp the step to one second less a tick
  assign step = (delay_step > MAX_STEP) ? MAX_STEP : delay_step;
  assign grow = (item.read_level > overflow_mark) && (item.write_fill != 16'd0);

  // Stop flag clears delay and floor before a step is applied
  assign base     = item.buffer_stopped ? '0 : dly_r;
  assign grow_sum = {1'b0, base.tenth_ms} + {1'b0, step};

  // Work out the updated delay and floor for the item in the input register
  always_comb begin
    dly_nxt = dly_r;
    if (item.req_type == REQ_INIT) begin
      dly_nxt.tenth_ms    = '0;
      dly_nxt.seconds     = '0;
      dly_nxt.floor_value = start_floor;
    end else if (grow) begin
      dly_nxt = base;
      if (grow_sum > {1'b0, TENTHS_PER_SEC}) begin
        dly_nxt.tenth_ms = 14'(grow_sum - {1'b0, TENTHS_PER_SEC});
        if (base.seconds != MAX16) begin
          dly_nxt.seconds = base.seconds + 16'd1;
        end
      end else begin
        dly_nxt.tenth_ms = grow_sum[13:0];
      end
      if (auto_floor && (base.floor_value != MAX16)) begin
        dly_nxt.floor_value = base.floor_value + 16'd1;
      end
    end else if (item.buffer_stopped) begin
      dly_nxt = '0;
    end else if ((dly_r.tenth_ms == 14'd0) && (dly_r.seconds == 16'd0)) begin
      dly_nxt = dly_r;
    end else if ((dly_r.tenth_ms < step) && (dly_r.seconds == 16'd0)) begin
      dly_nxt.tenth_ms = '0;
    end else if (dly_r.tenth_ms >= step) begin
      dly_nxt.tenth_ms = dly_r.tenth_ms - step;
    end else begin
      dly_nxt.seconds  = dly_r.seconds - 16'd1;
      dly_nxt.tenth_ms = TENTHS_PER_SEC - step;
    end
  end

  // Commit when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_r <= '0;
    end else if (adv) begin
      dly_r <= dly_nxt;
    end
  end

  assign delay_new = dly_nxt;

endmodule

@@ hw/rtl/trdt_reload.sv @@
// Reload computation: reference timestamp registers, elapsed time plus
// extra delay, wrap to 16 bits and floor. Depends on trdt_pkg.
`timescale 1ns / 1ps

module trdt_reload (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  trdt_pkg::item_t   item,
  input  trdt_pkg::delay_t  delay_new,
  output logic [15:0]       reload_value,
  output logic              floor_applied
);
  import trdt_pkg::*;

  logic [15:0] prev_seconds_r;
  logic [13:0] prev_tenth_ms_r;
  logic [13:0] frac;
  logic        earlier;
  logic [15:0] ref_sec;
  logic [13:0] ref_frac;
  logic [13:0] msr0;
  logic [15:0] secr0;
  logic [14:0] msum;
  logic [13:0] msr;
  logic        carry;
  logic [15:0] secr;
  logic [29:0] prod;
  logic [15:0] raw;

  // Clamp the fraction; the clamped value is also the new reference
  assign frac = (item.stamp_tenth_ms > BORROW_BASE) ? BORROW_BASE : item.stamp_tenth_ms;

  // A stamp earlier than the reference restarts the reference at zero
  assign earlier  = (item.stamp_seconds < prev_seconds_r) ||
                    ((item.stamp_seconds == prev_seconds_r) && (frac < prev_tenth_ms_r));
  assign ref_sec  = earlier ? 16'd0 : prev_seconds_r;
  assign ref_frac = earlier ? 14'd0 : prev_tenth_ms_r;

  // Elapsed time, borrowing one second when the fraction runs under
  always_comb begin
    if (frac >= ref_frac) begin
      msr0  = frac - ref_frac;
      secr0 = item.stamp_seconds - ref_sec;
    end else begin
      msr0  = BORROW_BASE - ref_frac + frac;
      secr0 = item.stamp_seconds - ref_sec - 16'd1;
    end
  end

  // Add the extra delay, carrying into seconds
  assign msum  = {1'b0, msr0} + {1'b0, delay_new.tenth_ms};
  assign carry = (msum >= {1'b0, TENTHS_PER_SEC});
  assign msr   = carry ? 14'(msum - {1'b0, TENTHS_PER_SEC}) : msum[13:0];
  assign secr  = secr0 + {15'd0, carry} + delay_new.seconds;

  // Scale seconds, wrap to 16 bits and raise to the floor
  assign prod = 30'(secr) * 30'(TENTHS_PER_SEC);
  assign raw  = prod[15:0] + {2'b00, msr};

  assign floor_applied = (raw < delay_new.floor_value);
  assign reload_value  = floor_applied ? delay_new.floor_value : raw;

  // Hold the reference timestamp of the last timestamped message
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_seconds_r  <= '0;
      prev_tenth_ms_r <= '0;
    end else if (adv && (item.req_type == REQ_STAMP)) begin
      prev_seconds_r  <= item.stamp_seconds;
      prev_tenth_ms_r <= frac;
    end
  end

endmodule

@@ tb/sv/trdt_reload_checker.sv @@
// Reload checker for the trace replay delay timer: follows config writes and
// input transfers, predicts each reload result and compares the results.
// Depends on trdt_pkg for the item layout, register indexes and constants.
`timescale 1ns / 1ps

module trdt_reload_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_stamp_seconds,
  input  logic [13:0] in_stamp_tenth_ms,
  input  logic [15:0] in_read_level,
  input  logic [15:0] in_write_fill,
  input  logic        in_buffer_stopped,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_reload_value,
  input  logic        out_floor_applied,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import trdt_pkg::*;

  typedef struct packed {
    logic [15:0] reload_value;
    logic        floor_applied;
  } reload_t;

  reload_t reload_q[$];

  // Register copies
  logic [13:0] step_reg;
  logic [15:0] mark_reg;
  logic        auto_reg;
  logic [15:0] start_reg;

  // Reference timestamp, adaptive extra delay and floor
  logic [15:0] ref_sec;
  logic [13:0] ref_frac;
  int unsigned extra_frac;
  logic [15:0] extra_sec;
  logic [15:0] floor_lvl;

  // Update the delay state for one item; returns 1 when a reload is due
  function automatic bit compute_reload(input item_t it, output reload_t res);
    int unsigned step;
    int unsigned frac;
    int unsigned msr;
    int unsigned secr;
    int unsigned wrapped;
    bit          grow;
    res  = '0;
    step = (step_reg > MAX_STEP) ? MAX_STEP : step_reg;
    if (it.req_type == REQ_INIT) begin
      extra_frac = 0;
      extra_sec  = '0;
      floor_lvl  = start_reg;
      return 1'b0;
    end
    frac = (it.stamp_tenth_ms > BORROW_BASE) ? BORROW_BASE : it.stamp_tenth_ms;
    grow = (it.read_level > mark_reg) && (it.write_fill != 16'd0);

    // a stop report wipes delay and floor before either direction
    if (it.buffer_stopped) begin
      extra_frac = 0;
      extra_sec  = '0;
      floor_lvl  = '0;
    end
    if (grow) begin
      extra_frac = extra_frac + step;
      if (extra_frac > TENTHS_PER_SEC) begin
        extra_frac = extra_frac - TENTHS_PER_SEC;
        if (extra_sec < MAX16) extra_sec = extra_sec + 16'd1;
      end
      if (auto_reg && floor_lvl < MAX16) floor_lvl = floor_lvl + 16'd1;
    end else if (!it.buffer_stopped && (extra_frac != 0 || extra_sec != 0)) begin
      if (extra_frac < step && extra_sec == 0) begin
        extra_frac = 0;
      end else if (extra_frac >= step) begin
        extra_frac = extra_frac - step;
      end else begin
        extra_sec  = extra_sec - 16'd1;
        extra_frac = TENTHS_PER_SEC - step;
      end
    end

    // an earlier stamp drops the reference back to zero
    if (it.stamp_seconds < ref_sec || (it.stamp_seconds == ref_sec && frac < ref_frac)) begin
      ref_sec  = '0;
      ref_frac = '0;
    end
    if (frac >= ref_frac) begin
      msr  = frac - ref_frac;
      secr = it.stamp_seconds - ref_sec;
    end else begin
      msr  = BORROW_BASE - ref_frac + frac;
      secr = it.stamp_seconds - ref_sec - 1;
    end
    msr = msr + extra_frac;
    if (msr >= TENTHS_PER_SEC) begin
      msr  = msr - TENTHS_PER_SEC;
      secr = secr + 1;
    end
    secr     = secr + extra_sec;
    ref_sec  = it.stamp_seconds;
    ref_frac = frac[13:0];

    wrapped = (((secr * TENTHS_PER_SEC) & 32'hFFFF) + msr) & 32'hFFFF;
    if (wrapped < floor_lvl) begin
      res.reload_value  = floor_lvl;
      res.floor_applied = 1'b1;
    end else begin
      res.reload_value  = wrapped[15:0];
      res.floor_applied = 1'b0;
    end
    return 1'b1;
  endfunction

  // Follow config writes, check results, then predict the accepted item
  always @(posedge clk) begin
    reload_t got;
    reload_t want;
    item_t   taken;
    if (!rst_n) begin
      step_reg   = 14'd100;
      mark_reg   = 16'd32768;
      auto_reg   = 1'b0;
      start_reg  = '0;
      ref_sec    = '0;
      ref_frac   = '0;
      extra_frac = 0;
      extra_sec  = '0;
      floor_lvl  = '0;
      fail_count = 0;
      reload_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DELAY_STEP:    step_reg  = cfg_data[13:0];
          CFG_OVERFLOW_MARK: mark_reg  = cfg_data;
          CFG_AUTO_FLOOR:    auto_reg  = cfg_data[0];
          CFG_START_FLOOR:   start_reg = cfg_data;
          default:           ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_reload_value, out_floor_applied};
        if (reload_q.size() == 0) begin
          $error("result with nothing expected: reload_value %0d floor_applied %0d",
                 got.reload_value, got.floor_applied);
          fail_count++;
        end else begin
          want = reload_q.pop_front();
          if (got.reload_value !== want.reload_value) begin
            $error("reload_value: expected %0d, got %0d", want.reload_value, got.reload_value);
            fail_count++;
          end
          if (got.floor_applied !== want.floor_applied) begin
            $error("floor_applied: expected %0d, got %0d",
                   want.floor_applied, got.floor_applied);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        taken = {in_req_type, in_stamp_seconds, in_stamp_tenth_ms,
                 in_read_level, in_write_fill, in_buffer_stopped};
        if (compute_reload(taken, want)) reload_q.push_back(want);
      end
    end
    pending = reload_q.size();
  end

endmodule

@@ tb/sv/trace_replay_delay_timer_tb.sv @@
// Testbench top for the trace replay delay timer: clock, reset, config
// settings, trace stimulus with idle and stall phases, and the verdict.
// Depends on trdt_pkg, trace_replay_delay_timer and trdt_reload_checker.
`timescale 1ns / 1ps

module trace_replay_delay_timer_tb;
  import trdt_pkg::*;

  localparam int LIMIT        = 500000;
  localparam int SETTLE       = 6;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic        in_req_type       = 1'b0;
  logic [15:0] in_stamp_seconds  = '0;
  logic [13:0] in_stamp_tenth_ms = '0;
  logic [15:0] in_read_level     = '0;
  logic [15:0] in_write_fill     = '0;
  logic        in_buffer_stopped = 1'b0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [15:0] out_reload_value;
  logic        out_floor_applied;
  logic        cfg_wr_en         = 1'b0;
  logic [1:0]  cfg_index         = '0;
  logic [15:0] cfg_data          = '0;

  int          fail_count;
  int          pending;
  int          cycles    = 0;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          grow_pct  = 50;
  logic [15:0] set_mark  = 16'd32768;
  logic [15:0] trace_sec = '0;
  int unsigned trace_frac = 0;

  // delay_step, overflow_mark, auto_floor, start_floor per phase
  logic [15:0] cfg_table [PHASES][4] = '{
    '{16'd100,  16'd32768, 16'd0, 16'd0},
    '{16'd1,    16'd0,     16'd1, 16'd65534},
    '{16'd9999, 16'd65535, 16'd1, 16'd65535},
    '{16'hFFFF, 16'd100,   16'd1, 16'd20000},
    '{16'd0,    16'd40000, 16'd0, 16'd300},
    '{16'd5000, 16'd16384, 16'd1, 16'd0},
    '{16'd0,    16'd0,     16'd0, 16'd0},
    '{16'd0,    16'd0,     16'd0, 16'd0}
  };

  trace_replay_delay_timer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_stamp_seconds  (in_stamp_seconds),
    .in_stamp_tenth_ms (in_stamp_tenth_ms),
    .in_read_level     (in_read_level),
    .in_write_fill     (in_write_fill),
    .in_buffer_stopped (in_buffer_stopped),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reload_value  (out_reload_value),
    .out_floor_applied (out_floor_applied),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  trdt_reload_checker reload_watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_stamp_seconds  (in_stamp_seconds),
    .in_stamp_tenth_ms (in_stamp_tenth_ms),
    .in_read_level     (in_read_level),
    .in_write_fill     (in_write_fill),
    .in_buffer_stopped (in_buffer_stopped),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_reload_value  (out_reload_value),
    .out_floor_applied (out_floor_applied),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at the phase's rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic req, input logic [15:0] sec, input logic [13:0] frac,
                           input logic [15:0] rlev, input logic [15:0] wfill,
                           input logic stop);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_stamp_seconds  <= sec;
    in_stamp_tenth_ms <= frac;
    in_read_level     <= rlev;
    in_write_fill     <= wfill;
    in_buffer_stopped <= stop;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, drain every expected reload, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all four registers back to back
  task automatic apply_setting(input logic [15:0] step, input logic [15:0] mark,
                               input logic [15:0] auto_on, input logic [15:0] start);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DELAY_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= CFG_OVERFLOW_MARK;
    cfg_data  <= mark;
    @(posedge clk);
    cfg_index <= CFG_AUTO_FLOOR;
    cfg_data  <= auto_on;
    @(posedge clk);
    cfg_index <= CFG_START_FLOOR;
    cfg_data  <= start;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    set_mark = mark;
  endtask

  // Next message of a mostly forward-running trace, with jumps back and noise
  task automatic send_trace_item();
    logic        req;
    logic        stop;
    logic [15:0] rlev;
    logic [15:0] wfill;
    int unsigned pick;
    int unsigned adv;
    req  = ($urandom_range(99) < 4) ? REQ_INIT : REQ_STAMP;
    pick = $urandom_range(99);
    if (pick < 80) begin
      adv        = trace_frac + $urandom_range(2500);
      trace_sec  = 16'(trace_sec + adv / 10000 + (($urandom_range(9) == 0) ? 1 : 0));
      trace_frac = adv % 10000;
    end else if (pick < 90) begin
      trace_sec  = 16'($urandom_range(trace_sec));
      trace_frac = $urandom_range(9999);
    end else begin
      trace_sec  = 16'($urandom);
      trace_frac = $urandom_range(16383);
    end
    if ($urandom_range(99) < grow_pct && set_mark != 16'hFFFF)
      rlev = 16'($urandom_range(32'hFFFF, set_mark + 1));
    else
      rlev = 16'($urandom_range(set_mark));
    pick = $urandom_range(99);
    if (pick < 75) wfill = 16'($urandom);
    else if (pick < 80) wfill = 16'd1;
    else wfill = '0;
    stop = ($urandom_range(99) < 4);
    send_item(req, trace_sec, trace_frac[13:0], rlev, wfill, stop);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: largest step so carries and borrows of the delay show quickly
    apply_setting(16'd9999, 16'd32768, 16'd1, 16'd500);
    send_item(REQ_STAMP, 16'd0,     14'd0,     16'd0,     16'd0,     1'b0);
    send_item(REQ_INIT,  16'd0,     14'd0,     16'd0,     16'd0,     1'b0);
    send_item(REQ_STAMP, 16'd0,     14'd0,     16'd0,     16'd0,     1'b0);
    send_item(REQ_STAMP, 16'd1,     14'd5000,  16'hFFFF,  16'hFFFF,  1'b0);
    send_item(REQ_STAMP, 16'd1,     14'h3FFF,  16'd32769, 16'd1,     1'b0);
    send_item(REQ_STAMP, 16'd2,     14'd100,   16'd100,   16'd5,     1'b0);
    send_item(REQ_STAMP, 16'd2,     14'd200,   16'd0,     16'd0,     1'b0);
    send_item(REQ_STAMP, 16'd2,     14'd300,   16'd0,     16'd0,     1'b0);
    send_item(REQ_STAMP, 16'd1,     14'd0,     16'd40000, 16'd0,     1'b0);
    send_item(REQ_STAMP, 16'hFFFF,  14'd9999,  16'hFFFF,  16'hFFFF,  1'b1);
    send_item(REQ_STAMP, 16'hFFFF,  14'd9999,  16'd0,     16'd0,     1'b1);
    send_item(REQ_STAMP, 16'hFFFF,  14'h3FFF,  16'd0,     16'd0,     1'b0);
    send_item(REQ_STAMP, 16'd0,     14'd9999,  16'd0,     16'd0,     1'b0);
    send_item(REQ_STAMP, 16'd3,     14'd0,     16'd32768, 16'hFFFF,  1'b0);
    send_item(REQ_INIT,  16'hFFFF,  14'h3FFF,  16'hFFFF,  16'hFFFF,  1'b1);
    send_item(REQ_STAMP, 16'd10,    14'd1234,  16'hFFFF,  16'd0,     1'b0);
    send_item(REQ_STAMP, 16'd12,    14'd9000,  16'hFFFF,  16'hAAAA,  1'b0);
    send_item(REQ_STAMP, 16'd12,    14'd9001,  16'hFFFF,  16'h5555,  1'b0);

    // Random phases, one setting each, cycling through the idle profiles
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph >= 6) begin
        for (int r = 0; r < 4; r++) cfg_table[ph][r] = 16'($urandom);
      end
      apply_setting(cfg_table[ph][CFG_DELAY_STEP], cfg_table[ph][CFG_OVERFLOW_MARK],
                    cfg_table[ph][CFG_AUTO_FLOOR], cfg_table[ph][CFG_START_FLOOR]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 87; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 87; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      grow_pct = (ph % 2 == 1) ? 70 : 35;
      for (int n = 0; n < PHASE_ITEMS; n++) send_trace_item();
    end

    wait_idle();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
